@@ src/vdw_pkg.sv @@
package vdw_pkg;

  localparam int CLASS_COUNT = 256;
  localparam int IDX_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int CLS_W       = 8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PAIR = 1'b1;

  localparam logic MODE_HHG = 1'b0;
  localparam logic MODE_GEO = 1'b1;

  localparam logic [16:0] RMIN_MAX  = 17'h1FFFF;
  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] depth;
    logic [15:0] reduction;
  } entry_t;

  // integer square root pipeline, one root bit per stage
  localparam int SQ_ROOT_W = 24;
  localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_st_t;

  // restoring divider pipeline, one quotient bit per stage
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_Q_W   = 18;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_Q_W-1:0]   quo;
  } div_st_t;

  // accept edge to the edge at which the result beat is taken
  localparam int OUT_LAT = 2 + SQ_STEPS + 1 + DIV_Q_W + 1;

  typedef struct packed {
    logic        mode;
    logic        r_zero;
    logic        d_zero;
    logic [15:0] reduction;
  } side_t;

  function automatic idx_t cls_idx(input logic [CLS_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[IDX_W-1:0];
  endfunction

  function automatic logic cls_ok(input logic [CLS_W-1:0] c);
    return 32'(c) < 32'(CLASS_COUNT);
  endfunction

endpackage

@@ src/vdw_pair_combining_rule.sv @@
// Van der Waals pair combiner. Load beats write one class entry and give no
// result; pair beats give one result, on the result ports for one cycle with
// result_valid_o. busy_o is always low: one beat of either kind is taken every
// cycle, and a load is seen by a pair in the very next cycle. The latency is
// set by the HHG depth path: a 24-stage square root followed by an 18-stage
// divider, one bit per stage. The receiver cannot stall, so no result is ever
// held back.
module vdw_pair_combining_rule (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        combine_mode_we_i,
  input  logic        combine_mode_i,
  input  logic        action_i,
  input  logic [7:0]  class_a_i,
  input  logic [7:0]  class_b_i,
  input  logic [15:0] load_radius_i,
  input  logic [15:0] load_depth_i,
  input  logic [15:0] load_reduction_i,
  output logic        result_valid_o,
  output logic [16:0] pair_rmin_o,
  output logic [15:0] pair_depth_o,
  output logic [15:0] first_reduction_o
);

  localparam int SQ_OUT  = 2 + vdw_pkg::SQ_STEPS;
  localparam int D_OUT   = SQ_OUT + 1 + vdw_pkg::DIV_Q_W;
  localparam int R_OUT   = 4 + vdw_pkg::DIV_Q_W;
  localparam int FIN     = D_OUT;
  localparam int EE_LEN  = SQ_OUT - 2;
  localparam int SD_LEN  = FIN - 2;
  localparam int QR_LEN  = FIN - R_OUT;
  localparam int RT_LEN  = FIN - SQ_OUT;
  localparam int VLD_LEN = FIN - 1;

  logic mode_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vdw_pkg::MODE_HHG;
    end else if (combine_mode_we_i) begin
      mode_q <= combine_mode_i;
    end
  end

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: table read
  vdw_pkg::entry_t wentry;
  vdw_pkg::entry_t ent_a;
  vdw_pkg::entry_t ent_b;

  assign wentry = '{radius: load_radius_i, depth: load_depth_i, reduction: load_reduction_i};

  vdw_class_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (accept && action_i == vdw_pkg::ACT_LOAD && vdw_pkg::cls_ok(class_a_i)),
    .waddr_i   (vdw_pkg::cls_idx(class_a_i)),
    .wdata_i   (wentry),
    .raddr_a_i (vdw_pkg::cls_idx(class_a_i)),
    .raddr_b_i (vdw_pkg::cls_idx(class_b_i)),
    .rdata_a_o (ent_a),
    .rdata_b_o (ent_b)
  );

  logic vld1_q;
  logic ok_a1_q;
  logic ok_b1_q;
  logic mode1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept && action_i == vdw_pkg::ACT_PAIR;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_a1_q <= vdw_pkg::cls_ok(class_a_i);
    ok_b1_q <= vdw_pkg::cls_ok(class_b_i);
    mode1_q <= mode_q;
  end

  // stage 2: products
  vdw_pkg::entry_t ea;
  vdw_pkg::entry_t eb;

  assign ea = ok_a1_q ? ent_a : '0;
  assign eb = ok_b1_q ? ent_b : '0;

  logic [15:0] ri2_q, rj2_q;
  logic [31:0] rr_a2_q, rr_b2_q, ee2_q, rirj2_q;
  logic [16:0] esum2_q;
  vdw_pkg::side_t side2_q;

  always_ff @(posedge clk_i) begin
    ri2_q   <= ea.radius;
    rj2_q   <= eb.radius;
    rr_a2_q <= ea.radius * ea.radius;
    rr_b2_q <= eb.radius * eb.radius;
    ee2_q   <= ea.depth * eb.depth;
    rirj2_q <= ea.radius * eb.radius;
    esum2_q <= 17'(ea.depth) + 17'(eb.depth);
    side2_q <= '{mode:      mode1_q,
                 r_zero:    (ea.radius == 16'd0) && (eb.radius == 16'd0),
                 d_zero:    (ea.depth == 16'd0) && (eb.depth == 16'd0),
                 reduction: ea.reduction};
  end

  // square roots: g = isqrt(Ei*Ej << 16), and isqrt(4*Ri*Rj)
  logic [vdw_pkg::SQ_ROOT_W-1:0] g_root;
  logic [vdw_pkg::SQ_ROOT_W-1:0] r_root;

  vdw_isqrt u_sq_depth (
    .clk_i  (clk_i),
    .rad_i  ({ee2_q, 16'd0}),
    .root_o (g_root)
  );

  vdw_isqrt u_sq_radius (
    .clk_i  (clk_i),
    .rad_i  ({14'd0, rirj2_q, 2'b00}),
    .root_o (r_root)
  );

  // stages 3-4: HHG radius numerator and denominator
  logic [47:0] cube_a3_q, cube_b3_q;
  logic [32:0] rden3_q, rden4_q;
  logic [48:0] rnum4_q;

  always_ff @(posedge clk_i) begin
    cube_a3_q <= rr_a2_q * ri2_q;
    cube_b3_q <= rr_b2_q * rj2_q;
    rden3_q   <= 33'(rr_a2_q) + 33'(rr_b2_q);
    rnum4_q   <= 49'(cube_a3_q) + 49'(cube_b3_q);
    rden4_q   <= rden3_q;
  end

  logic [vdw_pkg::DIV_Q_W-1:0] q_rad;

  vdw_div u_div_radius (
    .clk_i (clk_i),
    .num_i (rnum4_q),
    .den_i (rden4_q),
    .quo_o (q_rad)
  );

  // hold Ei*Ej and Ei+Ej until g is out
  logic [31:0] ee_dl_q   [EE_LEN];
  logic [16:0] esum_dl_q [EE_LEN];

  always_ff @(posedge clk_i) begin
    ee_dl_q[0]   <= ee2_q;
    esum_dl_q[0] <= esum2_q;
    for (int i = 1; i < EE_LEN; i++) begin
      ee_dl_q[i]   <= ee_dl_q[i-1];
      esum_dl_q[i] <= esum_dl_q[i-1];
    end
  end

  // HHG depth: (4*Ei*Ej*256) / ((Ei+Ej)*256 + 2*g)
  logic [48:0] dnum_q;
  logic [32:0] dden_q;

  always_ff @(posedge clk_i) begin
    dnum_q <= 49'({ee_dl_q[EE_LEN-1], 10'd0});
    dden_q <= 33'({esum_dl_q[EE_LEN-1], 8'd0}) + 33'({g_root, 1'b0});
  end

  logic [vdw_pkg::DIV_Q_W-1:0] q_depth;

  vdw_div u_div_depth (
    .clk_i (clk_i),
    .num_i (dnum_q),
    .den_i (dden_q),
    .quo_o (q_depth)
  );

  // align the early results with the depth quotient
  logic [vdw_pkg::DIV_Q_W-1:0]   qr_dl_q [QR_LEN];
  logic [vdw_pkg::SQ_ROOT_W-1:0] rr_dl_q [RT_LEN];
  logic [vdw_pkg::SQ_ROOT_W-1:0] gg_dl_q [RT_LEN];
  vdw_pkg::side_t                sd_dl_q [SD_LEN];
  logic [VLD_LEN-1:0]            vld_q;

  always_ff @(posedge clk_i) begin
    qr_dl_q[0] <= q_rad;
    for (int i = 1; i < QR_LEN; i++) begin
      qr_dl_q[i] <= qr_dl_q[i-1];
    end
    rr_dl_q[0] <= r_root;
    gg_dl_q[0] <= g_root;
    for (int i = 1; i < RT_LEN; i++) begin
      rr_dl_q[i] <= rr_dl_q[i-1];
      gg_dl_q[i] <= gg_dl_q[i-1];
    end
    sd_dl_q[0] <= side2_q;
    for (int i = 1; i < SD_LEN; i++) begin
      sd_dl_q[i] <= sd_dl_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_LEN-2:0], vld1_q};
    end
  end

  // final select and saturation
  vdw_pkg::side_t side_f;
  logic [23:0]    rsel;
  logic [23:0]    dsel;

  assign side_f = sd_dl_q[SD_LEN-1];

  always_comb begin
    if (side_f.mode == vdw_pkg::MODE_HHG) begin
      rsel = side_f.r_zero ? 24'd0 : 24'(qr_dl_q[QR_LEN-1]);
      dsel = side_f.d_zero ? 24'd0 : 24'(q_depth);
    end else begin
      rsel = rr_dl_q[RT_LEN-1];
      dsel = {8'd0, gg_dl_q[RT_LEN-1][23:8]};
    end
  end

  logic        res_vld_q;
  logic [16:0] rmin_q;
  logic [15:0] depth_q;
  logic [15:0] red_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= vld_q[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rmin_q  <= (rsel > 24'(vdw_pkg::RMIN_MAX)) ? vdw_pkg::RMIN_MAX : rsel[16:0];
    depth_q <= (dsel > 24'(vdw_pkg::DEPTH_MAX)) ? vdw_pkg::DEPTH_MAX : dsel[15:0];
    red_q   <= side_f.reduction;
  end

  assign result_valid_o    = res_vld_q;
  assign pair_rmin_o       = rmin_q;
  assign pair_depth_o      = depth_q;
  assign first_reduction_o = red_q;

endmodule

@@ src/vdw_class_ram.sv @@
module vdw_class_ram (
  input  logic            clk_i,
  input  logic            we_i,
  input  vdw_pkg::idx_t   waddr_i,
  input  vdw_pkg::entry_t wdata_i,
  input  vdw_pkg::idx_t   raddr_a_i,
  input  vdw_pkg::idx_t   raddr_b_i,
  output vdw_pkg::entry_t rdata_a_o,
  output vdw_pkg::entry_t rdata_b_o
);

  vdw_pkg::entry_t mem [vdw_pkg::CLASS_COUNT];
  vdw_pkg::entry_t rdata_a_q;
  vdw_pkg::entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ src/vdw_isqrt.sv @@
module vdw_isqrt (
  input  logic                          clk_i,
  input  logic [vdw_pkg::SQ_RAD_W-1:0]  rad_i,
  output logic [vdw_pkg::SQ_ROOT_W-1:0] root_o
);

  localparam int RAD_W  = vdw_pkg::SQ_RAD_W;
  localparam int REM_W  = vdw_pkg::SQ_REM_W;
  localparam int ROOT_W = vdw_pkg::SQ_ROOT_W;
  localparam int STEPS  = vdw_pkg::SQ_STEPS;

  vdw_pkg::sq_st_t st_q [STEPS];
  vdw_pkg::sq_st_t st_d [STEPS];

  function automatic vdw_pkg::sq_st_t sq_step(input vdw_pkg::sq_st_t s);
    vdw_pkg::sq_st_t n;
    logic [REM_W+1:0] ext;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    ext   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    diff  = ext - trial;
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (ext >= trial) begin
      n.rem  = diff[REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = ext[REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    vdw_pkg::sq_st_t s0;
    s0.rad  = rad_i;
    s0.rem  = '0;
    s0.root = '0;
    st_d[0] = sq_step(s0);
    for (int i = 1; i < STEPS; i++) begin
      st_d[i] = sq_step(st_q[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STEPS; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  assign root_o = st_q[STEPS-1].root;

endmodule

@@ src/vdw_div.sv @@
module vdw_div (
  input  logic                          clk_i,
  input  logic [vdw_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [vdw_pkg::DIV_DEN_W-1:0] den_i,
  output logic [vdw_pkg::DIV_Q_W-1:0]   quo_o
);

  localparam int NUM_W = vdw_pkg::DIV_NUM_W;
  localparam int Q_W   = vdw_pkg::DIV_Q_W;

  vdw_pkg::div_st_t st_q [Q_W];
  vdw_pkg::div_st_t st_d [Q_W];

  // quotient is known to fit in Q_W bits, so start at den << (Q_W-1)
  function automatic vdw_pkg::div_st_t div_step(input vdw_pkg::div_st_t s, input int sh);
    vdw_pkg::div_st_t n;
    logic [NUM_W:0] r_ext;
    logic [NUM_W:0] d_ext;
    logic [NUM_W:0] diff;
    r_ext = {1'b0, s.rem};
    d_ext = (NUM_W+1)'(s.den) << sh;
    diff  = r_ext - d_ext;
    n.den = s.den;
    if (r_ext >= d_ext) begin
      n.rem = diff[NUM_W-1:0];
      n.quo = {s.quo[Q_W-2:0], 1'b1};
    end else begin
      n.rem = s.rem;
      n.quo = {s.quo[Q_W-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    vdw_pkg::div_st_t s0;
    s0.rem  = num_i;
    s0.den  = den_i;
    s0.quo  = '0;
    st_d[0] = div_step(s0, Q_W-1);
    for (int i = 1; i < Q_W; i++) begin
      st_d[i] = div_step(st_q[i-1], Q_W-1-i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Q_W; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  assign quo_o = st_q[Q_W-1].quo;

endmodule

@@ src/vdw_checker.sv @@
module vdw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic action_i,
  input logic result_valid_o
);

  logic pair_beat;
  assign pair_beat = start_i && !busy_o && (action_i == vdw_pkg::ACT_PAIR);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_pair_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_beat |-> ##(vdw_pkg::OUT_LAT) result_valid_o)
    else $error("pair beat lost");

  a_result_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pair_beat, vdw_pkg::OUT_LAT))
    else $error("result without pair beat");

endmodule

bind vdw_pair_combining_rule vdw_checker u_vdw_checker (.*);

@@ verif/vdw_pair_combining_rule_tb.sv @@
module vdw_pair_combining_rule_tb;

  typedef struct packed {
    logic [16:0] rmin;
    logic [15:0] depth;
    logic [15:0] reduction;
  } pair_res_t;

  typedef struct packed {
    logic        mode;
    logic        action;
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [15:0] radius;
    logic [15:0] depth;
    logic [15:0] reduction;
    logic        typed;
    pair_res_t   res;
  } dir_row_t;

  localparam int WDOG_LIMIT = 5000;
  localparam int N_RANDOM   = 1200;

  // short names for the stimulus table
  localparam logic HHG = vdw_pkg::MODE_HHG;
  localparam logic GEO = vdw_pkg::MODE_GEO;
  localparam logic LDE = vdw_pkg::ACT_LOAD;
  localparam logic PRE = vdw_pkg::ACT_PAIR;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        combine_mode_we_i = 1'b0;
  logic        combine_mode_i = 1'b0;
  logic        action_i = 1'b0;
  logic [7:0]  class_a_i = '0;
  logic [7:0]  class_b_i = '0;
  logic [15:0] load_radius_i = '0;
  logic [15:0] load_depth_i = '0;
  logic [15:0] load_reduction_i = '0;
  logic        result_valid_o;
  logic [16:0] pair_rmin_o;
  logic [15:0] pair_depth_o;
  logic [15:0] first_reduction_o;

  vdw_pair_combining_rule u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  vdw_pkg::entry_t class_mirror [vdw_pkg::CLASS_COUNT];
  bit              class_loaded [vdw_pkg::CLASS_COUNT];
  logic            mode_mirror;
  pair_res_t       pending_pairs [$];
  int              n_errors;
  int              idle_cycles;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic pair_res_t combine_pair(input logic [7:0] ca, input logic [7:0] cb);
    logic [63:0] ri, rj, ei, ej, rmin, dep, rden, g, dden;
    pair_res_t   r;
    ri = 64'(class_mirror[ca].radius);
    rj = 64'(class_mirror[cb].radius);
    ei = 64'(class_mirror[ca].depth);
    ej = 64'(class_mirror[cb].depth);
    if (mode_mirror == vdw_pkg::MODE_HHG) begin
      rden = ri * ri + rj * rj;
      rmin = (rden == 0) ? 64'd0 : (ri * ri * ri + rj * rj * rj) / rden;
      g    = int_sqrt((ei * ej) << 16);
      dden = ((ei + ej) << 8) + 2 * g;
      dep  = (dden == 0) ? 64'd0 : ((4 * ei * ej) << 8) / dden;
    end else begin
      rmin = int_sqrt(4 * ri * rj);
      dep  = int_sqrt(ei * ej);
    end
    r.rmin      = (rmin > 64'(vdw_pkg::RMIN_MAX)) ? vdw_pkg::RMIN_MAX : rmin[16:0];
    r.depth     = (dep > 64'(vdw_pkg::DEPTH_MAX)) ? vdw_pkg::DEPTH_MAX : dep[15:0];
    r.reduction = class_mirror[ca].reduction;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        pair_res_t e;
        e = pending_pairs.pop_front();
        if (pair_rmin_o !== e.rmin) begin
          $error("pair_rmin exp %0d got %0d", e.rmin, pair_rmin_o);
          n_errors++;
        end
        if (pair_depth_o !== e.depth) begin
          $error("pair_depth exp %0d got %0d", e.depth, pair_depth_o);
          n_errors++;
        end
        if (first_reduction_o !== e.reduction) begin
          $error("first_reduction exp %0d got %0d", e.reduction, first_reduction_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || result_valid_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic act, input logic [7:0] ca, input logic [7:0] cb,
                           input logic [15:0] r, input logic [15:0] d, input logic [15:0] red,
                           input logic typed, input pair_res_t typed_res);
    @(negedge clk_i);
    start_i          = 1'b1;
    action_i         = act;
    class_a_i        = ca;
    class_b_i        = cb;
    load_radius_i    = r;
    load_depth_i     = d;
    load_reduction_i = red;
    do @(posedge clk_i); while (busy_o);
    if (act == vdw_pkg::ACT_LOAD) begin
      class_mirror[ca] = '{radius: r, depth: d, reduction: red};
      class_loaded[ca] = 1'b1;
    end else begin
      pending_pairs.push_back(typed ? typed_res : combine_pair(ca, cb));
    end
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    idle_gap(1);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (vdw_pkg::OUT_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_pipe();
    @(negedge clk_i);
    combine_mode_we_i = 1'b1;
    combine_mode_i    = m;
    @(negedge clk_i);
    combine_mode_we_i = 1'b0;
    combine_mode_i    = 1'($urandom_range(0, 1));
    mode_mirror       = m;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t  dir_rows [$];
  pair_res_t no_res;

  initial begin
    int       k, n_loaded;
    logic [7:0] ca, cb;
    n_errors    = 0;
    idle_cycles = 0;
    mode_mirror = vdw_pkg::MODE_HHG;
    no_res      = '0;
    for (k = 0; k < vdw_pkg::CLASS_COUNT; k++) begin
      class_mirror[k] = '0;
      class_loaded[k] = 1'b0;
    end
    //     mode action a      b       radius    depth     red       typed  result
    dir_rows = '{
      '{HHG, LDE, 8'd0,   8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b0, no_res},
      '{HHG, LDE, 8'd255, 8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, no_res},
      '{HHG, LDE, 8'd1,   8'd0,   16'h1000, 16'h4000, 16'h8000, 1'b0, no_res},
      '{HHG, LDE, 8'd2,   8'd0,   16'h2345, 16'h0123, 16'h00FF, 1'b0, no_res},
      // zero denominators on both HHG paths
      '{HHG, PRE, 8'd0,   8'd0,   16'h0, 16'h0, 16'h0, 1'b1, '{17'd0, 16'd0, 16'd0}},
      '{HHG, PRE, 8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 1'b1,
        '{17'd65535, 16'hFFFF, 16'hFFFF}},
      '{HHG, PRE, 8'd0,   8'd255, 16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{HHG, PRE, 8'd255, 8'd0,   16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{HHG, PRE, 8'd1,   8'd2,   16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{HHG, PRE, 8'd2,   8'd255, 16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{GEO, PRE, 8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 1'b1,
        '{17'd131070, 16'hFFFF, 16'hFFFF}},
      '{GEO, PRE, 8'd0,   8'd0,   16'h0, 16'h0, 16'h0, 1'b1, '{17'd0, 16'd0, 16'd0}},
      '{GEO, PRE, 8'd0,   8'd255, 16'h0, 16'h0, 16'h0, 1'b1, '{17'd0, 16'd0, 16'd0}},
      '{GEO, PRE, 8'd1,   8'd2,   16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{GEO, LDE, 8'd3,   8'd0,   16'h0001, 16'h0001, 16'h0000, 1'b0, no_res},
      // load then pair on the next beat
      '{GEO, PRE, 8'd3,   8'd255, 16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{GEO, PRE, 8'd255, 8'd3,   16'h0, 16'h0, 16'h0, 1'b0, no_res},
      '{HHG, PRE, 8'd3,   8'd3,   16'h0, 16'h0, 16'h0, 1'b0, no_res}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_mirror) write_mode(dir_rows[i].mode);
      send_beat(dir_rows[i].action, dir_rows[i].ca, dir_rows[i].cb, dir_rows[i].radius,
                dir_rows[i].depth, dir_rows[i].reduction, dir_rows[i].typed, dir_rows[i].res);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 250 == 249) write_mode(1'($urandom_range(0, 1)));
      if (k == 600) drain_pipe();
      if (k < N_RANDOM - 200 && $urandom_range(0, 9) == 0) idle_gap($urandom_range(1, 16));
      n_loaded = 0;
      foreach (class_loaded[c]) if (class_loaded[c]) n_loaded++;
      if ($urandom_range(0, 9) < 3 || n_loaded < 8) begin
        send_beat(vdw_pkg::ACT_LOAD, 8'($urandom), 8'($urandom), rand_field(), rand_field(),
                  rand_field(), 1'b0, no_res);
      end else begin
        do ca = 8'($urandom); while (!class_loaded[ca]);
        do cb = 8'($urandom); while (!class_loaded[cb]);
        send_beat(vdw_pkg::ACT_PAIR, ca, cb, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b0, no_res);
      end
    end

    idle_gap(1);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (vdw_pkg::OUT_LAT + 4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
